@@ design/sla_pkg.sv @@
`timescale 1ns / 1ps
package sla_pkg;

  localparam int PULSE_PERIOD     = 1000;
  localparam int FADE_TICKS       = 3000;
  localparam int FLASH_STEP_TICKS = 150;
  localparam int FLASH_STEP_COUNT = 6;

  // alarm brightness is c*(15P+170x)/(100P)
  localparam int ALARM_DEN = 100 * PULSE_PERIOD;
  localparam int MUL_MAX   = (ALARM_DEN > FADE_TICKS) ? ALARM_DEN : FADE_TICKS;

  localparam int PP_W   = $clog2(PULSE_PERIOD);
  localparam int FADE_W = $clog2(FADE_TICKS + 1);
  localparam int M_W    = $clog2(MUL_MAX + 1);
  localparam int ACC_W  = M_W + 8;
  localparam int CNT_W  = 4;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_FLASH = 2'd2;

  localparam logic [2:0] MODE_STAND   = 3'd0;
  localparam logic [2:0] MODE_SIT     = 3'd1;
  localparam logic [2:0] MODE_WALK    = 3'd2;
  localparam logic [2:0] MODE_DIZZY   = 3'd3;
  localparam logic [2:0] MODE_ALARM   = 3'd4;
  localparam logic [2:0] MODE_RECOVER = 3'd5;

  localparam logic [2:0] REG_STAND = 3'd0;
  localparam logic [2:0] REG_SIT   = 3'd1;
  localparam logic [2:0] REG_WALK  = 3'd2;
  localparam logic [2:0] REG_DIZZY = 3'd3;
  localparam logic [2:0] REG_ALARM = 3'd4;
  localparam logic [2:0] REG_FLASH = 3'd5;

  localparam logic [23:0] RST_STAND = 24'h0000FF;
  localparam logic [23:0] RST_SIT   = 24'h00FFFF;
  localparam logic [23:0] RST_WALK  = 24'h00FF00;
  localparam logic [23:0] RST_DIZZY = 24'hFFBF00;
  localparam logic [23:0] RST_ALARM = 24'hFF0000;
  localparam logic [23:0] RST_FLASH = 24'hA000FF;

  typedef struct packed {
    logic             show;
    logic             calc;
    logic [23:0]      rgb;
    logic [23:0]      a_rgb;
    logic [23:0]      b_rgb;
    logic [M_W-1:0]   m1;
    logic [M_W-1:0]   m2;
    logic [ACC_W-1:0] dvs;
  } sla_job_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } sla_lane_ctl_t;

  typedef struct packed {
    logic       show;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } sla_pix_t;

endpackage

@@ design/sla_in_if.sv @@
`timescale 1ns / 1ps
interface sla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] new_mode;

  modport source (output valid, output kind, output new_mode, input ready);
  modport sink (input valid, input kind, input new_mode, output ready);
endinterface

@@ design/sla_out_if.sv @@
`timescale 1ns / 1ps
interface sla_out_if;
  logic       valid;
  logic       ready;
  logic       show;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output show, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input show, input red, input green, input blue,
                output ready);
endinterface

@@ design/sla_lane.sv @@
`timescale 1ns / 1ps
module sla_lane (
  input  logic                         clk,
  input  sla_pkg::sla_lane_ctl_t       ctl,
  input  logic [7:0]                   a,
  input  logic [7:0]                   b,
  input  logic [sla_pkg::M_W-1:0]      m1,
  input  logic [sla_pkg::M_W-1:0]      m2,
  input  logic [sla_pkg::ACC_W-1:0]    dvs,
  output logic [7:0]                   q
);

  logic [7:0]                a_r;
  logic [7:0]                b_r;
  logic [sla_pkg::M_W-1:0]   m1_r;
  logic [sla_pkg::M_W-1:0]   m2_r;
  logic [sla_pkg::ACC_W-1:0] acc_r;
  logic [sla_pkg::ACC_W-1:0] d_r;
  logic [7:0]                q_r;
  logic [sla_pkg::ACC_W-1:0] mul_nxt;

  // one multiplier bit per cycle, MSB first: acc = 2*acc + a_bit*m1 + b_bit*m2
  always_comb begin
    mul_nxt = {acc_r[sla_pkg::ACC_W-2:0], 1'b0};
    if (a_r[7]) begin
      mul_nxt = mul_nxt + sla_pkg::ACC_W'(m1_r);
    end
    if (b_r[7]) begin
      mul_nxt = mul_nxt + sla_pkg::ACC_W'(m2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= a;
      b_r   <= b;
      m1_r  <= m1;
      m2_r  <= m2;
      acc_r <= '0;
      d_r   <= dvs;
      q_r   <= '0;
    end else if (ctl.mul) begin
      acc_r <= mul_nxt;
      a_r   <= {a_r[6:0], 1'b0};
      b_r   <= {b_r[6:0], 1'b0};
    end else if (ctl.div) begin
      // restoring divide, one quotient bit per cycle, divisor walks down
      if (acc_r >= d_r) begin
        acc_r <= acc_r - d_r;
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        q_r   <= {q_r[6:0], 1'b0};
      end
      d_r <= d_r >> 1;
    end
  end

  assign q = q_r;

endmodule

@@ design/sla_ctrl.sv @@
`timescale 1ns / 1ps
module sla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_wdata,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic [2:0]        new_mode,
  output sla_pkg::sla_job_t job
);

  logic [23:0] stand_r, sit_r, walk_r, dizzy_r, alarm_r, flash_r;

  logic [2:0]                 mode_r, mode_nxt;
  logic [sla_pkg::PP_W-1:0]   pp_r, pp_nxt;
  logic [sla_pkg::FADE_W-1:0] fade_r, fade_nxt;
  logic                       fl_act_r, fl_act_nxt;
  logic [2:0]                 fl_step_r, fl_step_nxt;
  logic [7:0]                 fl_el_r, fl_el_nxt;

  logic [1:0]               steady_sel;
  logic [23:0]              steady_rgb;
  logic [7:0]               el_inc;
  logic [2:0]               step_inc;
  logic [sla_pkg::PP_W-1:0] x;
  logic [sla_pkg::M_W-1:0]  num;

  assign steady_sel = (kind == sla_pkg::KIND_SET) ? new_mode[1:0] : mode_r[1:0];

  always_comb begin
    case (steady_sel)
      2'd0:    steady_rgb = stand_r;
      2'd1:    steady_rgb = sit_r;
      2'd2:    steady_rgb = walk_r;
      default: steady_rgb = dizzy_r;
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    pp_nxt      = pp_r;
    fade_nxt    = fade_r;
    fl_act_nxt  = fl_act_r;
    fl_step_nxt = fl_step_r;
    fl_el_nxt   = fl_el_r;
    el_inc      = fl_el_r;
    step_inc    = fl_step_r;
    x           = '0;
    num         = '0;
    job         = '0;
    case (kind)
      sla_pkg::KIND_SET: begin
        if (new_mode <= sla_pkg::MODE_RECOVER) begin
          mode_nxt = new_mode;
          pp_nxt   = '0;
          fade_nxt = '0;
          if (new_mode <= sla_pkg::MODE_DIZZY) begin
            job.show = 1'b1;
            job.rgb  = steady_rgb;
          end
        end
      end
      sla_pkg::KIND_FLASH: begin
        fl_act_nxt  = 1'b1;
        fl_step_nxt = '0;
        fl_el_nxt   = '0;
      end
      sla_pkg::KIND_TICK: begin
        pp_nxt = (pp_r == sla_pkg::PP_W'(sla_pkg::PULSE_PERIOD - 1)) ? '0 : pp_r + 1'b1;
        if (fade_r < sla_pkg::FADE_W'(sla_pkg::FADE_TICKS)) begin
          fade_nxt = fade_r + 1'b1;
        end
        if (fl_act_r) begin
          el_inc    = (fl_el_r < 8'd255) ? fl_el_r + 8'd1 : fl_el_r;
          fl_el_nxt = el_inc;
          if (el_inc >= 8'(sla_pkg::FLASH_STEP_TICKS)) begin
            step_inc    = fl_step_r + 3'd1;
            fl_step_nxt = step_inc;
            fl_el_nxt   = '0;
            if (step_inc >= 3'(sla_pkg::FLASH_STEP_COUNT)) begin
              // flash over: hand the pixel back to the mode
              fl_act_nxt = 1'b0;
              if (mode_r <= sla_pkg::MODE_DIZZY) begin
                job.show = 1'b1;
                job.rgb  = steady_rgb;
              end
            end
          end
        end
        if (fl_act_nxt) begin
          job.show = 1'b1;
          job.rgb  = fl_step_nxt[0] ? 24'd0 : flash_r;
        end else if (mode_r == sla_pkg::MODE_ALARM) begin
          x = ({1'b0, pp_nxt, 1'b0} < (sla_pkg::PP_W + 2)'(sla_pkg::PULSE_PERIOD)) ?
              pp_nxt : sla_pkg::PP_W'(sla_pkg::PULSE_PERIOD) - pp_nxt;
          num = sla_pkg::M_W'(15 * sla_pkg::PULSE_PERIOD) +
                sla_pkg::M_W'(x) * sla_pkg::M_W'(170);
          job.calc  = 1'b1;
          job.a_rgb = alarm_r;
          job.m1    = num;
          job.dvs   = sla_pkg::ACC_W'(sla_pkg::ALARM_DEN) << 7;
        end else if (mode_r == sla_pkg::MODE_RECOVER) begin
          // f*(T-e) + w*e equals f*T + (w-f)*e without a sign
          job.calc  = 1'b1;
          job.a_rgb = dizzy_r;
          job.b_rgb = walk_r;
          job.m1    = sla_pkg::M_W'(sla_pkg::FADE_TICKS) - sla_pkg::M_W'(fade_nxt);
          job.m2    = sla_pkg::M_W'(fade_nxt);
          job.dvs   = sla_pkg::ACC_W'(sla_pkg::FADE_TICKS) << 7;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stand_r   <= sla_pkg::RST_STAND;
      sit_r     <= sla_pkg::RST_SIT;
      walk_r    <= sla_pkg::RST_WALK;
      dizzy_r   <= sla_pkg::RST_DIZZY;
      alarm_r   <= sla_pkg::RST_ALARM;
      flash_r   <= sla_pkg::RST_FLASH;
      mode_r    <= sla_pkg::MODE_STAND;
      pp_r      <= '0;
      fade_r    <= '0;
      fl_act_r  <= 1'b0;
      fl_step_r <= '0;
      fl_el_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sla_pkg::REG_STAND: stand_r <= cfg_wdata;
          sla_pkg::REG_SIT:   sit_r   <= cfg_wdata;
          sla_pkg::REG_WALK:  walk_r  <= cfg_wdata;
          sla_pkg::REG_DIZZY: dizzy_r <= cfg_wdata;
          sla_pkg::REG_ALARM: alarm_r <= cfg_wdata;
          sla_pkg::REG_FLASH: flash_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        mode_r    <= mode_nxt;
        pp_r      <= pp_nxt;
        fade_r    <= fade_nxt;
        fl_act_r  <= fl_act_nxt;
        fl_step_r <= fl_step_nxt;
        fl_el_r   <= fl_el_nxt;
      end
    end
  end

endmodule

@@ design/status_led_animator.sv @@
`timescale 1ns / 1ps
// Status pixel animator. Each accepted item (tick, mode set, flash start) yields
// exactly one result; show=0 results carry black. Items that draw nothing, a
// steady color or a flash step have their result ready in the cycle after the
// transfer. Alarm pulse and recovery fade ticks are computed by three channel
// lanes that each run 8 bit-serial multiply steps and 8 restoring divide steps;
// then the color is registered and moved on to the output register.
// One item is in work at a time; a new item is taken while the previous result
// waits in the output register.
// Configuration is six 24-bit packed colors (red in bits 23:16), index 0..5.
module status_led_animator (
  input  logic             clk,
  input  logic             rst_n,
  sla_in_if.sink           in_ch,
  sla_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_WRAP = 3'b100
  } sla_state_t;

  sla_state_t state_r;
  logic [sla_pkg::CNT_W-1:0] cnt_r;

  sla_pkg::sla_job_t      job;
  sla_pkg::sla_lane_ctl_t lane_ctl;
  sla_pkg::sla_pix_t      res_r, out_r;
  logic                   res_valid_r, out_valid_r;
  logic                   accept;
  logic                   out_free;
  logic [7:0]             lane_q [3];

  assign in_ch.ready = (state_r == ST_IDLE) && !res_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  sla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .kind      (in_ch.kind),
    .new_mode  (in_ch.new_mode),
    .job       (job)
  );

  assign lane_ctl.load = accept && job.calc;
  assign lane_ctl.mul  = (state_r == ST_CALC) && !cnt_r[sla_pkg::CNT_W-1];
  assign lane_ctl.div  = (state_r == ST_CALC) && cnt_r[sla_pkg::CNT_W-1];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sla_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .a   (job.a_rgb[8*i +: 8]),
      .b   (job.b_rgb[8*i +: 8]),
      .m1  (job.m1),
      .m2  (job.m2),
      .dvs (job.dvs),
      .q   (lane_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // advance the pending result into the output register
      if (res_valid_r && out_free) begin
        out_valid_r <= 1'b1;
        res_valid_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (job.calc) begin
              state_r <= ST_CALC;
              cnt_r   <= '0;
            end else begin
              res_valid_r <= 1'b1;
            end
          end
        end
        ST_CALC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          res_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !job.calc) begin
      res_r.show  <= job.show;
      res_r.red   <= job.rgb[23:16];
      res_r.green <= job.rgb[15:8];
      res_r.blue  <= job.rgb[7:0];
    end else if (state_r == ST_WRAP) begin
      res_r.show  <= 1'b1;
      res_r.red   <= lane_q[2];
      res_r.green <= lane_q[1];
      res_r.blue  <= lane_q[0];
    end
    if (res_valid_r && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.show  = out_r.show;
  assign out_ch.red   = out_r.red;
  assign out_ch.green = out_r.green;
  assign out_ch.blue  = out_r.blue;

endmodule

@@ tb/status_led_animator_tb.sv @@
`timescale 1ns / 1ps
module status_led_animator_tb;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [2:0] REG_UNUSED_LO  = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI  = 3'd7;

  localparam int COLORS_RANDOM  = 0;
  localparam int COLORS_WHITE   = 1;
  localparam int COLORS_BLACK   = 2;
  localparam int COLORS_EXTREME = 3;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 40;
  localparam int SETTLE      = 24;

  class pixel_scoreboard;
    logic [23:0]                colors [6];
    logic [2:0]                 mode;
    logic [sla_pkg::PP_W-1:0]   pulse_pos;
    logic [sla_pkg::FADE_W-1:0] fade_pos;
    bit                         flash_on;
    logic [2:0]                 flash_idx;
    logic [7:0]                 flash_cnt;
    sla_pkg::sla_pix_t          pending_pix [$];
    int errors, n_checked, n_ticks, n_sets, n_flashes, n_ignored;
    int n_alarm, n_fade, n_fade_full, n_flash_ends;

    function new();
      colors    = '{sla_pkg::RST_STAND, sla_pkg::RST_SIT, sla_pkg::RST_WALK,
                    sla_pkg::RST_DIZZY, sla_pkg::RST_ALARM, sla_pkg::RST_FLASH};
      mode      = sla_pkg::MODE_STAND;
      pulse_pos = '0;
      fade_pos  = '0;
      flash_on  = 1'b0;
      flash_idx = '0;
      flash_cnt = '0;
    endfunction

    function void write_color(logic [2:0] idx, logic [23:0] val);
      if (idx <= sla_pkg::REG_FLASH) colors[idx] = val;
    endfunction

    function int pending();
      return pending_pix.size();
    endfunction

    // triangle brightness from 0.15 to 1.0 over one pulse period
    function logic [23:0] pulse_color();
      int x, num, den, sh;
      logic [23:0] res;
      x = (2 * int'(pulse_pos) < sla_pkg::PULSE_PERIOD) ? int'(pulse_pos)
          : sla_pkg::PULSE_PERIOD - int'(pulse_pos);
      num = 15 * sla_pkg::PULSE_PERIOD + 170 * x;
      den = 100 * sla_pkg::PULSE_PERIOD;
      for (sh = 0; sh <= 16; sh += 8)
        res[sh +: 8] = 8'((int'(colors[sla_pkg::REG_ALARM][sh +: 8]) * num) / den);
      return res;
    endfunction

    function logic [23:0] fade_color();
      int f, w, n, sh;
      logic [23:0] res;
      for (sh = 0; sh <= 16; sh += 8) begin
        f = colors[sla_pkg::REG_DIZZY][sh +: 8];
        w = colors[sla_pkg::REG_WALK][sh +: 8];
        n = f * sla_pkg::FADE_TICKS + (w - f) * int'(fade_pos);
        res[sh +: 8] = 8'(n / sla_pkg::FADE_TICKS);
      end
      return res;
    endfunction

    function void note_item(logic [1:0] kind, logic [2:0] nm);
      bit                on;
      logic [23:0]       rgb;
      sla_pkg::sla_pix_t px;
      on  = 1'b0;
      rgb = '0;
      case (kind)
        sla_pkg::KIND_SET: begin
          n_sets++;
          if (nm <= sla_pkg::MODE_RECOVER) begin
            mode      = nm;
            pulse_pos = '0;
            fade_pos  = '0;
            if (nm <= sla_pkg::MODE_DIZZY) begin
              on  = 1'b1;
              rgb = colors[nm];
            end
          end else begin
            n_ignored++;
          end
        end
        sla_pkg::KIND_FLASH: begin
          n_flashes++;
          flash_on  = 1'b1;
          flash_idx = '0;
          flash_cnt = '0;
        end
        sla_pkg::KIND_TICK: begin
          n_ticks++;
          pulse_pos = (pulse_pos == sla_pkg::PULSE_PERIOD - 1) ? '0 : pulse_pos + 1'b1;
          if (fade_pos < sla_pkg::FADE_TICKS) fade_pos++;
          if (flash_on) begin
            if (flash_cnt != 8'hFF) flash_cnt++;
            if (flash_cnt >= sla_pkg::FLASH_STEP_TICKS) begin
              flash_idx++;
              flash_cnt = '0;
              // last step done: hand the pixel back to the mode
              if (flash_idx >= sla_pkg::FLASH_STEP_COUNT) begin
                flash_on = 1'b0;
                n_flash_ends++;
                if (mode <= sla_pkg::MODE_DIZZY) begin
                  on  = 1'b1;
                  rgb = colors[mode];
                end
              end
            end
          end
          if (flash_on) begin
            on  = 1'b1;
            rgb = flash_idx[0] ? 24'h000000 : colors[sla_pkg::REG_FLASH];
          end else if (mode == sla_pkg::MODE_ALARM) begin
            on  = 1'b1;
            rgb = pulse_color();
            n_alarm++;
          end else if (mode == sla_pkg::MODE_RECOVER) begin
            on  = 1'b1;
            rgb = fade_color();
            n_fade++;
            if (fade_pos == sla_pkg::FADE_TICKS) n_fade_full++;
          end
        end
        default: n_ignored++;
      endcase
      px.show  = on;
      px.red   = on ? rgb[23:16] : 8'h00;
      px.green = on ? rgb[15:8]  : 8'h00;
      px.blue  = on ? rgb[7:0]   : 8'h00;
      pending_pix.push_back(px);
    endfunction

    function void check_pixel(sla_pkg::sla_pix_t got);
      sla_pkg::sla_pix_t want;
      if (pending_pix.size() == 0) begin
        errors++;
        $error("result with nothing pending: show=%0d rgb=%02h%02h%02h",
               got.show, got.red, got.green, got.blue);
        return;
      end
      want = pending_pix.pop_front();
      n_checked++;
      if (got.show !== want.show) begin
        errors++;
        $error("show: expected %0d, got %0d", want.show, got.show);
      end
      if (got.red !== want.red) begin
        errors++;
        $error("red: expected %0d, got %0d", want.red, got.red);
      end
      if (got.green !== want.green) begin
        errors++;
        $error("green: expected %0d, got %0d", want.green, got.green);
      end
      if (got.blue !== want.blue) begin
        errors++;
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  sla_in_if  in_ch ();
  sla_out_if out_ch ();

  status_led_animator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_scoreboard sb;
  int burst_left  = 0;
  int sent_useful = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_item(in_ch.kind, in_ch.new_mode);
  end

  always @(posedge clk) begin
    sla_pkg::sla_pix_t got;
    got = {out_ch.show, out_ch.red, out_ch.green, out_ch.blue};
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_pixel(got);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("status_led_animator_tb failed");
        $finish;
      end
    end
  end

  // result side: stall segments of random style, or one long hold on request
  initial begin
    int style, len, per, c;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(10, 200);
        per   = $urandom_range(2, 5);
        for (c = 0; c < len; c++) begin
          case (style)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= (c % per == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic put(logic [1:0] kind, logic [2:0] nm);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.new_mode <= nm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind != KIND_UNUSED && !(kind == sla_pkg::KIND_SET && nm > sla_pkg::MODE_RECOVER))
      sent_useful++;
  endtask

  task automatic put_noise();
    if ($urandom_range(0, 1)) put(KIND_UNUSED, 3'($urandom));
    else put(sla_pkg::KIND_SET, 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_color(idx, val);
  endtask

  function automatic logic [7:0] chan_pick(int style);
    case (style)
      COLORS_WHITE: return 8'hFF;
      COLORS_BLACK: return 8'h00;
      COLORS_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       return 8'h00;
          1:       return 8'hFF;
          default: return 8'($urandom);
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_colors(int style);
    int i;
    for (i = sla_pkg::REG_STAND; i <= sla_pkg::REG_FLASH; i++)
      write_reg(3'(i), {chan_pick(style), chan_pick(style), chan_pick(style)});
    write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 24'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_episode();
    int r, n, tick_max;
    r = $urandom_range(0, 9);
    if (r < 5) put(sla_pkg::KIND_SET,
                   3'($urandom_range(sla_pkg::MODE_STAND, sla_pkg::MODE_RECOVER)));
    else if (r < 8) put(sla_pkg::KIND_FLASH, 3'($urandom));
    else put_noise();
    tick_max = ($urandom_range(0, 7) == 0) ? 120 : 30;
    n = $urandom_range(1, tick_max);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 92) put(sla_pkg::KIND_TICK, 3'($urandom));
      else if (r < 95) put(sla_pkg::KIND_SET,
                           3'($urandom_range(sla_pkg::MODE_STAND, sla_pkg::MODE_RECOVER)));
      else if (r < 98) put(sla_pkg::KIND_FLASH, 3'($urandom));
      else put_noise();
    end
  endtask

  // full flash (restarted once) over a long stretch in one mode
  task automatic long_run(logic [2:0] m, int n);
    int k;
    put(sla_pkg::KIND_SET, m);
    put(sla_pkg::KIND_FLASH, 3'($urandom));
    for (k = 0; k < n; k++) begin
      if (k == 20) put(sla_pkg::KIND_FLASH, 3'($urandom));
      put(sla_pkg::KIND_TICK, 3'($urandom));
    end
  endtask

  initial begin
    int ph, start;
    bit paused;
    sb = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= sla_pkg::KIND_TICK;
    in_ch.new_mode <= sla_pkg::MODE_STAND;
    cfg_we         <= 1'b0;
    cfg_index      <= sla_pkg::REG_STAND;
    cfg_wdata      <= 24'h000000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes past the last register must change nothing
    write_reg(REG_UNUSED_LO, 24'hFFFFFF);
    write_reg(REG_UNUSED_HI, 24'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);

    put(sla_pkg::KIND_SET, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_SIT);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_WALK);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_DIZZY);
    put(sla_pkg::KIND_SET, MODE_UNUSED_LO);
    put(sla_pkg::KIND_SET, MODE_UNUSED_HI);
    put(KIND_UNUSED, MODE_UNUSED_HI);
    put(KIND_UNUSED, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_TICK, MODE_UNUSED_HI);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_ALARM);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_TICK, MODE_UNUSED_HI);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_RECOVER);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_FLASH, MODE_UNUSED_HI);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_SIT);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_FLASH, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);
    put(sla_pkg::KIND_SET, sla_pkg::MODE_ALARM);
    put(sla_pkg::KIND_TICK, sla_pkg::MODE_STAND);

    for (ph = 1; ph <= 4; ph++) begin
      wait_drained();
      case (ph)
        1:       load_colors(COLORS_RANDOM);
        2:       load_colors(COLORS_WHITE);
        3:       load_colors(COLORS_BLACK);
        default: load_colors(COLORS_EXTREME);
      endcase
      // block the result side while items keep coming
      if (ph == 1) hold_req = 1'b1;
      start  = sent_useful;
      paused = 1'b0;
      while (sent_useful - start < PHASE_ITEMS) begin
        run_episode();
        if (!paused && sent_useful - start > PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      // pulse runs on under the flash, so the falling half shows once it ends
      if (ph == 2) long_run(sla_pkg::MODE_ALARM, $urandom_range(980, 1010));
    end

    wait_drained();
    $display("Run covered %0d results: %0d ticks, %0d mode sets, %0d flash starts,",
             sb.n_checked, sb.n_ticks, sb.n_sets, sb.n_flashes);
    $display("%0d ignored; pulse draws %0d, fade draws %0d (%0d fully faded), %0d flash ends.",
             sb.n_ignored, sb.n_alarm, sb.n_fade, sb.n_fade_full, sb.n_flash_ends);
    if (sb.errors == 0) begin
      $display("status_led_animator_tb passed");
    end else begin
      $display("status_led_animator_tb failed");
    end
    $finish;
  end

endmodule

@@ status_led_animator.f @@
design/sla_pkg.sv
design/sla_in_if.sv
design/sla_out_if.sv
design/sla_lane.sv
design/sla_ctrl.sv
design/status_led_animator.sv
tb/status_led_animator_tb.sv
